// ===== hw/rtl/esfc_pkg.sv =====
package esfc_pkg;

  // Frame check result codes, in the order the checks are made
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_PRELUDE_CRC  = 3'd2,
    ST_LENGTH       = 3'd3,
    ST_HEADERS_LONG = 3'd4,
    ST_MESSAGE_CRC  = 3'd5,
    ST_HEADER_PARSE = 3'd6
  } frame_status_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_INT32_TYPE  = 1'b0,
    CFG_STRING_TYPE = 1'b1
  } cfg_index_t;

  // Next-state view of the header walker, as seen by the frame checks
  typedef struct packed {
    logic        error;
    logic        at_record_start;
    logic [31:0] count;
  } hdr_walk_t;

  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
  localparam logic [7:0]  INT32_TYPE_RST  = 8'd4;
  localparam logic [7:0]  STRING_TYPE_RST = 8'd7;
  localparam int          PRELUDE_CRC_AT  = 8;   // first byte of the prelude CRC
  localparam int          PRELUDE_BYTES   = 12;
  localparam int          FRAME_OVERHEAD  = 16;  // prelude plus message CRC
  localparam int          MSG_CRC_BYTES   = 4;

  // Reflected CRC-32, one byte, with preset and final inversion
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

endpackage

// ===== hw/rtl/event_stream_frame_checker.sv =====
// Event-stream frame checker: takes one frame byte per transaction (in_frame_end
// on the last byte of the buffer) and, for each last byte, returns one result
// with the frame status, the header record count, the headers length and the
// payload length (the three counts read zero unless the status is OK). It
// checks the big-endian prelude, the prelude CRC-32, the total length, the
// message CRC-32 and the header record structure. Throughput is one byte per
// clock while input is not stalled. The last byte of a frame is held in the
// input register, then the result register loads from the byte-wide CRC
// update and header walker that sit between those two registers. Input is
// stalled only while a finished result is waiting for out_ready and the byte
// in the input register ends a frame. The user writes type codes through the
// cfg port only while no frame is open; the block does not enforce this.
module event_stream_frame_checker #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // frame bytes
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_header_count,
  output logic [31:0] out_headers_bytes,
  output logic [31:0] out_payload_bytes
);

  localparam logic [LENGTH_BITS-1:0] IDX_MAX = '1;

  // configuration registers
  logic [7:0] int32_code_r, string_code_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       in_fire, s1_go;

  // frame state
  logic [LENGTH_BITS-1:0] idx_r, idx_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] hdr_len_r, hdr_len_nxt;
  logic [31:0] shift_r, shift_nxt, shift_base;
  logic        pre_ok_r, pre_ok_nxt;
  logic        in_header, in_crc, pre_match;
  esfc_pkg::hdr_walk_t walk_nxt;

  // result register
  logic        out_valid_r;
  esfc_pkg::frame_status_t status_r, status_nxt;
  logic [31:0] hcount_r, hbytes_r, pbytes_r;
  logic [31:0] body_len, payload_sz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int32_code_r  <= esfc_pkg::INT32_TYPE_RST;
      string_code_r <= esfc_pkg::STRING_TYPE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        esfc_pkg::CFG_INT32_TYPE:  int32_code_r  <= cfg_data;
        esfc_pkg::CFG_STRING_TYPE: string_code_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage: a non-final byte always moves on; a final one needs the
  // result register free
  assign s1_go    = s1_valid_r && (!s1_end_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_data_byte;
      s1_end_r  <= in_frame_end;
    end
  end

  // Byte position decode
  assign in_crc    = (idx_r < LENGTH_BITS'(esfc_pkg::PRELUDE_CRC_AT)) ||
                     ((33'(idx_r) + 33'(esfc_pkg::MSG_CRC_BYTES)) < {1'b0, total_r});
  assign in_header = (idx_r >= LENGTH_BITS'(esfc_pkg::PRELUDE_BYTES)) &&
                     ((32'(idx_r) - 32'(esfc_pkg::PRELUDE_BYTES)) < hdr_len_r);

  // Prelude CRC comparison and byte shifter
  always_comb begin
    shift_base = (idx_r == LENGTH_BITS'(esfc_pkg::PRELUDE_CRC_AT)) ? crc_r : shift_r;
    pre_match  = (shift_base[31:24] == s1_byte_r);
    pre_ok_nxt = pre_ok_r;
    if (idx_r == LENGTH_BITS'(esfc_pkg::PRELUDE_CRC_AT)) begin
      pre_ok_nxt = pre_match;
    end else if (idx_r > LENGTH_BITS'(esfc_pkg::PRELUDE_CRC_AT) &&
                 idx_r < LENGTH_BITS'(esfc_pkg::PRELUDE_BYTES)) begin
      pre_ok_nxt = pre_ok_r && pre_match;
    end
    shift_nxt   = {shift_base[23:0], s1_byte_r};
    total_nxt   = (idx_r == LENGTH_BITS'(3)) ? shift_nxt : total_r;
    hdr_len_nxt = (idx_r == LENGTH_BITS'(7)) ? shift_nxt : hdr_len_r;
    crc_nxt     = in_crc ? esfc_pkg::crc32_byte(crc_r, s1_byte_r) : crc_r;
    idx_nxt     = (idx_r == IDX_MAX) ? idx_r : idx_r + LENGTH_BITS'(1);
  end

  esfc_hdr_walk u_hdr_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_go && in_header),
    .clear       (s1_go && s1_end_r),
    .data_byte   (s1_byte_r),
    .int32_code  (int32_code_r),
    .string_code (string_code_r),
    .walk_nxt    (walk_nxt)
  );

  // Frame state; cleared after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_go && s1_end_r)) begin
      idx_r     <= '0;
      crc_r     <= 32'd0;
      total_r   <= 32'd0;
      hdr_len_r <= 32'd0;
      shift_r   <= 32'd0;
      pre_ok_r  <= 1'b0;
    end else if (s1_go) begin
      idx_r     <= idx_nxt;
      crc_r     <= crc_nxt;
      total_r   <= total_nxt;
      hdr_len_r <= hdr_len_nxt;
      shift_r   <= shift_nxt;
      pre_ok_r  <= pre_ok_nxt;
    end
  end

  // Final checks, first failure wins
  assign body_len   = total_nxt - 32'(esfc_pkg::FRAME_OVERHEAD);
  assign payload_sz = body_len - hdr_len_nxt;

  always_comb begin
    if (idx_nxt < LENGTH_BITS'(esfc_pkg::FRAME_OVERHEAD)) begin
      status_nxt = esfc_pkg::ST_SHORT;
    end else if (!pre_ok_nxt) begin
      status_nxt = esfc_pkg::ST_PRELUDE_CRC;
    end else if (32'(idx_nxt) != total_nxt || idx_nxt == IDX_MAX) begin
      status_nxt = esfc_pkg::ST_LENGTH;
    end else if (hdr_len_nxt > body_len) begin
      status_nxt = esfc_pkg::ST_HEADERS_LONG;
    end else if (shift_nxt != crc_nxt) begin
      status_nxt = esfc_pkg::ST_MESSAGE_CRC;
    end else if (walk_nxt.error || !walk_nxt.at_record_start) begin
      status_nxt = esfc_pkg::ST_HEADER_PARSE;
    end else begin
      status_nxt = esfc_pkg::ST_OK;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_end_r) begin
      status_r <= status_nxt;
      if (status_nxt == esfc_pkg::ST_OK) begin
        hcount_r <= walk_nxt.count;
        hbytes_r <= hdr_len_nxt;
        pbytes_r <= payload_sz;
      end else begin
        hcount_r <= 32'd0;
        hbytes_r <= 32'd0;
        pbytes_r <= 32'd0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_header_count  = hcount_r;
  assign out_headers_bytes = hbytes_r;
  assign out_payload_bytes = pbytes_r;

endmodule

// ===== hw/rtl/esfc_hdr_walk.sv =====
module esfc_hdr_walk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                clear,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          int32_code,
  input  logic [7:0]          string_code,
  output esfc_pkg::hdr_walk_t walk_nxt
);

  typedef enum logic [6:0] {
    PH_NAME_LEN = 7'b0000001,
    PH_NAME     = 7'b0000010,
    PH_TYPE     = 7'b0000100,
    PH_INT      = 7'b0001000,
    PH_STR_HI   = 7'b0010000,
    PH_STR_LO   = 7'b0100000,
    PH_STR      = 7'b1000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] left_r, left_nxt;
  logic [31:0] count_r, count_nxt;
  logic        err_r, err_nxt;
  logic [15:0] left_dec;

  assign left_dec = left_r - 16'd1;

  // One record field byte per step; the walk freezes after an error
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    if (step && !err_r) begin
      case (phase_r)
        PH_NAME_LEN: begin
          left_nxt  = {8'd0, data_byte};
          phase_nxt = (data_byte != 8'd0) ? PH_NAME : PH_TYPE;
        end
        PH_NAME: begin
          left_nxt = left_dec;
          if (left_dec == 16'd0) phase_nxt = PH_TYPE;
        end
        PH_TYPE: begin
          // integer code wins when both codes are equal
          if (data_byte == int32_code) begin
            left_nxt  = 16'd4;
            phase_nxt = PH_INT;
          end else if (data_byte == string_code) begin
            phase_nxt = PH_STR_HI;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_INT, PH_STR: begin
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            count_nxt = count_r + 32'd1;
            phase_nxt = PH_NAME_LEN;
          end
        end
        PH_STR_HI: begin
          left_nxt  = {data_byte, 8'd0};
          phase_nxt = PH_STR_LO;
        end
        PH_STR_LO: begin
          left_nxt = {left_r[15:8], data_byte};
          if ({left_r[15:8], data_byte} == 16'd0) begin
            count_nxt = count_r + 32'd1;
            phase_nxt = PH_NAME_LEN;
          end else begin
            phase_nxt = PH_STR;
          end
        end
        default: err_nxt = 1'b1;
      endcase
    end
  end

  assign walk_nxt.error           = err_nxt;
  assign walk_nxt.at_record_start = (phase_nxt == PH_NAME_LEN);
  assign walk_nxt.count           = count_nxt;

  // Walker state; cleared at the end of every frame
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r <= PH_NAME_LEN;
      left_r  <= 16'd0;
      count_r <= 32'd0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== tb/tb_event_stream_frame_checker.sv =====
`timescale 1ns / 100ps

module tb_event_stream_frame_checker;

  localparam logic [31:0] CRC32_REFLECTED = 32'hEDB88320;
  localparam int          SETTLE_CYCLES   = 4;
  localparam int          LONG_HOLD       = 400;
  localparam int          PHASE_BYTES     = 130;
  localparam int          PHASE_FRAMES    = 2;
  localparam int          NUM_PHASES      = 6;

  // header walker position inside one record
  typedef enum logic [2:0] {
    W_NAME_LEN,
    W_NAME,
    W_TYPE,
    W_INT,
    W_STR_HI,
    W_STR_LO,
    W_STR
  } walk_phase_t;

  // how a generated frame is broken, if at all
  typedef enum logic [3:0] {
    DEF_NONE,
    DEF_SHORT,
    DEF_PRELUDE_CRC,
    DEF_TOTAL_LEN,
    DEF_HDR_LONG,
    DEF_MSG_CRC,
    DEF_BAD_TYPE,
    DEF_CUT_RECORD,
    DEF_TRAILING,
    DEF_NOISE,
    DEF_RAND_LENGTHS,
    DEF_RAND_HEADERS
  } defect_t;

  typedef struct packed {
    esfc_pkg::frame_status_t status;
    logic [31:0]             records;
    logic [31:0]             hdr_bytes;
    logic [31:0]             payload;
  } frame_report_t;

  typedef struct packed {
    defect_t                 defect;
    int                      n_rec;
    int                      len;
    bit                      typed;
    esfc_pkg::frame_status_t status;
  } frame_case_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_frame_end;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [31:0] out_header_count;
  logic [31:0] out_headers_bytes;
  logic [31:0] out_payload_bytes;

  event_stream_frame_checker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_header_count (out_header_count),
    .out_headers_bytes(out_headers_bytes),
    .out_payload_bytes(out_payload_bytes)
  );

  always #5 clk = ~clk;

  // hard stop in case a handshake never completes
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // frame checker state as the predictor tracks it
  logic [31:0] fc_pos;
  logic [31:0] fc_crc;
  logic [31:0] fc_total;
  logic [31:0] fc_hdr_len;
  logic [31:0] fc_window;
  logic        fc_prelude_ok;
  walk_phase_t fc_phase;
  logic [15:0] fc_left;
  logic [31:0] fc_records;
  logic        fc_hdr_err;
  logic [7:0]  int_code;
  logic [7:0]  str_code;

  frame_report_t expected_reports[$];
  logic [7:0]    frame_q[$];
  logic [7:0]    hdr_q[$];
  frame_case_t   directed_cases[13];
  int            mismatches;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            hold_cycles;

  // bit-serial reflected CRC-32 with preset and final inversion
  function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    r = ~acc;
    for (int i = 0; i < 8; i++) begin
      r = {1'b0, r[31:1]} ^ ((r[0] ^ b[i]) ? CRC32_REFLECTED : 32'h0);
    end
    return ~r;
  endfunction

  function automatic void clear_frame_model();
    fc_pos        = '0;
    fc_crc        = '0;
    fc_total      = '0;
    fc_hdr_len    = '0;
    fc_window     = '0;
    fc_prelude_ok = 1'b0;
    fc_phase      = W_NAME_LEN;
    fc_left       = '0;
    fc_records    = '0;
    fc_hdr_err    = 1'b0;
  endfunction

  function automatic void record_closed();
    fc_records = fc_records + 32'd1;
    fc_phase   = W_NAME_LEN;
  endfunction

  // one byte of the header section through the record walker
  function automatic void walk_header_byte(input logic [7:0] b);
    if (fc_hdr_err) return;
    case (fc_phase)
      W_NAME_LEN: begin
        fc_left  = {8'd0, b};
        fc_phase = (b != 8'd0) ? W_NAME : W_TYPE;
      end
      W_NAME: begin
        fc_left = fc_left - 16'd1;
        if (fc_left == 16'd0) fc_phase = W_TYPE;
      end
      W_TYPE: begin
        if (b == int_code) begin
          fc_left  = 16'd4;
          fc_phase = W_INT;
        end else if (b == str_code) begin
          fc_phase = W_STR_HI;
        end else begin
          fc_hdr_err = 1'b1;
        end
      end
      W_INT, W_STR: begin
        fc_left = fc_left - 16'd1;
        if (fc_left == 16'd0) record_closed();
      end
      W_STR_HI: begin
        fc_left  = {b, 8'd0};
        fc_phase = W_STR_LO;
      end
      W_STR_LO: begin
        fc_left = fc_left | {8'd0, b};
        if (fc_left == 16'd0) record_closed();
        else fc_phase = W_STR;
      end
      default: fc_hdr_err = 1'b1;
    endcase
  endfunction

  // advance the predictor by one byte; returns 1 when the byte closes a frame
  function automatic bit predict_byte(input logic [7:0] b, input logic last,
                                      output frame_report_t rep);
    logic [31:0] idx;
    idx = fc_pos;
    rep = '0;

    // prelude CRC compare, MSB first
    if (idx == 32'd8) begin
      fc_window     = fc_crc;
      fc_prelude_ok = 1'b1;
    end
    if (idx >= 32'd8 && idx < 32'd12 && fc_window[31:24] != b) fc_prelude_ok = 1'b0;

    // message CRC skips the trailing CRC word
    if (idx < 32'd8 || ({1'b0, idx} + 33'd4) < {1'b0, fc_total}) fc_crc = crc_step(fc_crc, b);

    if (idx >= 32'd12 && (idx - 32'd12) < fc_hdr_len) walk_header_byte(b);

    fc_window = {fc_window[23:0], b};
    if (idx == 32'd3) fc_total = fc_window;
    if (idx == 32'd7) fc_hdr_len = fc_window;
    if (idx != '1) fc_pos = idx + 32'd1;

    if (!last) return 1'b0;

    // first failing check wins
    if (fc_pos < 32'd16) rep.status = esfc_pkg::ST_SHORT;
    else if (!fc_prelude_ok) rep.status = esfc_pkg::ST_PRELUDE_CRC;
    else if (fc_pos != fc_total || fc_pos == '1) rep.status = esfc_pkg::ST_LENGTH;
    else if (fc_hdr_len > fc_total - 32'd16) rep.status = esfc_pkg::ST_HEADERS_LONG;
    else if (fc_window != fc_crc) rep.status = esfc_pkg::ST_MESSAGE_CRC;
    else if (fc_hdr_err || fc_phase != W_NAME_LEN) rep.status = esfc_pkg::ST_HEADER_PARSE;
    else rep.status = esfc_pkg::ST_OK;

    if (rep.status == esfc_pkg::ST_OK) begin
      rep.records   = fc_records;
      rep.hdr_bytes = fc_hdr_len;
      rep.payload   = fc_total - 32'd16 - fc_hdr_len;
    end
    clear_frame_model();
    return 1'b1;
  endfunction

  function automatic void push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) frame_q.push_back(w[8*i +: 8]);
  endfunction

  // one well-formed header record with random name and value
  function automatic void add_record();
    int name_len;
    int str_len;
    name_len = ($urandom_range(39) == 0) ? 255 : $urandom_range(5);
    hdr_q.push_back(8'(name_len));
    repeat (name_len) hdr_q.push_back(8'($urandom));
    if ($urandom_range(1) == 1) begin
      hdr_q.push_back(int_code);
      repeat (4) hdr_q.push_back(8'($urandom));
    end else begin
      str_len = ($urandom_range(29) == 0) ? $urandom_range(270, 256) : $urandom_range(8);
      hdr_q.push_back(str_code);
      hdr_q.push_back(8'(str_len >> 8));
      hdr_q.push_back(8'(str_len));
      repeat (str_len) hdr_q.push_back(8'($urandom));
    end
  endfunction

  // assemble a frame in frame_q, broken the way defect says
  task automatic build_frame(input defect_t defect, input int n_rec, input int len);
    logic [31:0] total_f;
    logic [31:0] hdr_f;
    logic [31:0] crc;
    logic [7:0]  bad;
    int          n;
    frame_q.delete();
    hdr_q.delete();
    if (defect == DEF_SHORT || defect == DEF_NOISE) begin
      repeat (len) frame_q.push_back(8'($urandom));
    end else begin
      if (defect == DEF_RAND_HEADERS) repeat ($urandom_range(12)) hdr_q.push_back(8'($urandom));
      else repeat (n_rec) add_record();

      // trailing record with a type byte that matches neither code
      if (defect == DEF_BAD_TYPE) begin
        do bad = 8'($urandom); while (bad == int_code || bad == str_code);
        n = $urandom_range(3);
        hdr_q.push_back(8'(n));
        repeat (n) hdr_q.push_back(8'($urandom));
        hdr_q.push_back(bad);
        repeat (4) hdr_q.push_back(8'($urandom));
      end

      total_f = 32'(16 + hdr_q.size() + len);
      hdr_f   = 32'(hdr_q.size());
      case (defect)
        DEF_TOTAL_LEN: total_f = ($urandom_range(1) == 1) ? total_f + $urandom_range(8, 1)
                                                          : total_f - $urandom_range(8, 1);
        DEF_HDR_LONG:     hdr_f = hdr_f + 32'(len) + $urandom_range(4, 1);
        DEF_CUT_RECORD:   hdr_f = hdr_f - 32'd1;
        DEF_RAND_LENGTHS: begin
          total_f = $urandom;
          hdr_f   = $urandom;
        end
        default: ;
      endcase

      // prelude
      push_word(total_f);
      push_word(hdr_f);
      crc = '0;
      for (int i = 0; i < 8; i++) crc = crc_step(crc, frame_q[i]);
      if (defect == DEF_PRELUDE_CRC) crc = crc ^ (32'd1 << $urandom_range(31));
      push_word(crc);

      if (defect == DEF_RAND_LENGTHS) begin
        repeat ($urandom_range(30, 4)) frame_q.push_back(8'($urandom));
      end else begin
        foreach (hdr_q[i]) frame_q.push_back(hdr_q[i]);
        repeat (len) frame_q.push_back(8'($urandom));
        crc = '0;
        foreach (frame_q[i]) crc = crc_step(crc, frame_q[i]);
        if (defect == DEF_MSG_CRC) crc = crc ^ (32'd1 << $urandom_range(31));
        push_word(crc);
        if (defect == DEF_TRAILING) repeat ($urandom_range(3, 1)) frame_q.push_back(8'($urandom));
      end
    end
  endtask

  // one input transaction; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_frame_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // send frame_q; typed rows queue their hand-written status instead of the prediction
  task automatic send_frame(input bit typed, input esfc_pkg::frame_status_t typed_status);
    frame_report_t rep;
    logic          last;
    for (int i = 0; i < frame_q.size(); i++) begin
      last = (i == frame_q.size() - 1);
      send_byte(frame_q[i], last);
      if (predict_byte(frame_q[i], last, rep)) begin
        if (typed) begin
          rep        = '0;
          rep.status = typed_status;
        end
        expected_reports.push_back(rep);
      end
    end
  endtask

  // config write transaction; caller drops cfg_valid after the last one
  task automatic write_reg(input esfc_pkg::cfg_index_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == esfc_pkg::CFG_INT32_TYPE) int_code = val;
    else str_code = val;
    @(negedge clk);
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result check against the oldest outstanding frame
  always @(posedge clk) begin
    frame_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result transaction: status %0d", out_status);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_header_count !== want.records) begin
          $error("header_count: expected %0d, got %0d", want.records, out_header_count);
          mismatches++;
        end
        if (out_headers_bytes !== want.hdr_bytes) begin
          $error("headers_bytes: expected %0d, got %0d", want.hdr_bytes, out_headers_bytes);
          mismatches++;
        end
        if (out_payload_bytes !== want.payload) begin
          $error("payload_bytes: expected %0d, got %0d", want.payload, out_payload_bytes);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int          phase_bytes;
    int          phase_frames;
    int          pick;
    int          n_rec;
    int          len;
    defect_t     defect;
    logic [7:0]  new_int;
    logic [7:0]  new_str;

    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = 1'b0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_data_byte   = '0;
    in_frame_end   = 1'b0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    int_code       = esfc_pkg::INT32_TYPE_RST;
    str_code       = esfc_pkg::STRING_TYPE_RST;
    clear_frame_model();

    // directed frames at reset type codes
    directed_cases = '{
      '{DEF_SHORT,        0,  1, 1'b1, esfc_pkg::ST_SHORT},
      '{DEF_SHORT,        0, 15, 1'b1, esfc_pkg::ST_SHORT},
      '{DEF_NONE,         0,  0, 1'b1, esfc_pkg::ST_OK},         // empty frame, no headers
      '{DEF_NONE,         2,  5, 1'b0, esfc_pkg::ST_OK},
      '{DEF_PRELUDE_CRC,  1,  2, 1'b1, esfc_pkg::ST_PRELUDE_CRC},
      '{DEF_TOTAL_LEN,    1,  3, 1'b1, esfc_pkg::ST_LENGTH},
      '{DEF_HDR_LONG,     1,  0, 1'b1, esfc_pkg::ST_HEADERS_LONG},
      '{DEF_MSG_CRC,      2,  4, 1'b1, esfc_pkg::ST_MESSAGE_CRC},
      '{DEF_BAD_TYPE,     1,  1, 1'b1, esfc_pkg::ST_HEADER_PARSE},
      '{DEF_CUT_RECORD,   2,  2, 1'b1, esfc_pkg::ST_HEADER_PARSE},
      '{DEF_TRAILING,     0,  1, 1'b1, esfc_pkg::ST_LENGTH},     // bytes past total length
      '{DEF_RAND_HEADERS, 0,  3, 1'b0, esfc_pkg::ST_OK},
      '{DEF_NOISE,        0, 20, 1'b0, esfc_pkg::ST_OK}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_cases[k]) begin
      build_frame(directed_cases[k].defect, directed_cases[k].n_rec, directed_cases[k].len);
      send_frame(directed_cases[k].typed, directed_cases[k].status);
    end

    // random phases, each with its own type codes and idle profile
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);

      case (ph)
        0: begin new_int = 8'd0;   new_str = 8'd255; end
        1: begin new_int = 8'd255; new_str = 8'd0;   end
        2: begin new_int = 8'd9;   new_str = 8'd9;   end   // same code in both registers
        5: begin new_int = esfc_pkg::INT32_TYPE_RST; new_str = esfc_pkg::STRING_TYPE_RST; end
        default: begin new_int = 8'($urandom); new_str = 8'($urandom); end
      endcase
      write_reg(esfc_pkg::CFG_INT32_TYPE, new_int);
      write_reg(esfc_pkg::CFG_STRING_TYPE, new_str);
      cfg_valid <= 1'b0;

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase

      phase_bytes  = 0;
      phase_frames = 0;
      while (phase_bytes < PHASE_BYTES || phase_frames < PHASE_FRAMES) begin
        // receiver holds off while frames keep coming, so input backs up
        if (ph == 0 && phase_frames == 1) begin
          in_valid    <= 1'b0;
          hold_cycles  = LONG_HOLD;
          @(negedge clk);
        end
        // sender waits for every outstanding result
        if (ph == 2 && phase_frames == 1) begin
          in_valid <= 1'b0;
          while (expected_reports.size() != 0) @(negedge clk);
          @(negedge clk);
        end

        pick  = $urandom_range(99);
        n_rec = $urandom_range(4);
        len   = $urandom_range(24);
        if (pick < 62) defect = DEF_NONE;
        else if (pick < 65) defect = DEF_PRELUDE_CRC;
        else if (pick < 68) defect = DEF_TOTAL_LEN;
        else if (pick < 71) defect = DEF_HDR_LONG;
        else if (pick < 74) defect = DEF_MSG_CRC;
        else if (pick < 79) defect = DEF_BAD_TYPE;
        else if (pick < 84) defect = DEF_CUT_RECORD;
        else if (pick < 87) defect = DEF_TRAILING;
        else if (pick < 91) defect = DEF_SHORT;
        else if (pick < 94) defect = DEF_NOISE;
        else if (pick < 96) defect = DEF_RAND_LENGTHS;
        else defect = DEF_RAND_HEADERS;
        if (defect == DEF_CUT_RECORD && n_rec == 0) n_rec = 1;
        if (defect == DEF_SHORT) len = $urandom_range(15, 1);
        if (defect == DEF_NOISE) len = $urandom_range(40, 16);

        build_frame(defect, n_rec, len);
        send_frame(1'b0, esfc_pkg::ST_OK);
        phase_bytes  += frame_q.size();
        phase_frames++;
      end
    end

    // drain, then let the pipeline settle
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES * 2) @(negedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== event_stream_frame_checker.f =====
hw/rtl/esfc_pkg.sv
hw/rtl/esfc_hdr_walk.sv
hw/rtl/event_stream_frame_checker.sv
tb/tb_event_stream_frame_checker.sv
